// ----- rtl/assert_macros.svh -----
// assertion macros of the heap queue rtl, included by the sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is held
`define MHPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define MHPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/mhpq_pkg.sv -----
// shared constants, types and codes of the heap priority queue
package mhpq_pkg;

    // heap capacity and derived widths
    localparam int MAX_ENTRIES = 1023;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES + 1);
    localparam int RAM_DEPTH   = 2 ** ADDR_W;
    localparam int KEY_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 10;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [ADDR_W-1:0]       t_addr;
    // child index, one bit wider than a slot address
    typedef logic [ADDR_W:0]         t_idx;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // request from the sequencer to the heap memory
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_key  wdata;
        t_addr raddr_a;
        t_addr raddr_b;
    } t_ram_req;

endpackage

// ----- rtl/mhpq_in_if.sv -----
// input channel: operation word with valid/ready handshake
interface mhpq_in_if;
    logic            valid;
    logic            ready;
    logic            op;
    mhpq_pkg::t_key  value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

// ----- rtl/mhpq_out_if.sv -----
// output channel: result word with valid/ready handshake
interface mhpq_out_if;
    logic                          valid;
    logic                          ready;
    mhpq_pkg::t_key                popped;
    logic [mhpq_pkg::STATUS_W-1:0] status;
    logic [mhpq_pkg::COUNT_W-1:0]  count;

    modport source (output valid, output popped, output status, output count, input ready);
    modport sink   (input valid, input popped, input status, input count, output ready);
endinterface

// ----- rtl/mhpq_ram.sv -----
// heap store: one write port, two registered read ports
module mhpq_ram (
    input  logic                i_clk,
    input  mhpq_pkg::t_ram_req  i_req,
    output mhpq_pkg::t_key      o_rdata_a,
    output mhpq_pkg::t_key      o_rdata_b
);

    mhpq_pkg::t_key r_mem [mhpq_pkg::RAM_DEPTH];
    mhpq_pkg::t_key r_rdata_a;
    mhpq_pkg::t_key r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // read ports, registered
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_req.raddr_a];
        r_rdata_b <= r_mem[i_req.raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- rtl/mhpq_ctrl.sv -----
// heap sequencer: entry count, sift up and sift down walks, result register
`include "assert_macros.svh"

module mhpq_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mhpq_in_if.sink              i_in,
    mhpq_out_if.source           o_out,
    output mhpq_pkg::t_ram_req   o_ram_req,
    input  mhpq_pkg::t_key       i_rdata_a,
    input  mhpq_pkg::t_key       i_rdata_b
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_POP,
        S_DOWN,
        S_RES
    } t_state;

    t_state                        r_state,      n_state;
    mhpq_pkg::t_addr               r_cnt,        n_cnt;
    mhpq_pkg::t_addr               r_hole,       n_hole;
    mhpq_pkg::t_key                r_key,        n_key;
    mhpq_pkg::t_key                r_popped,     n_popped;
    mhpq_pkg::t_status             r_status,     n_status;
    logic                          r_out_valid,  n_out_valid;
    mhpq_pkg::t_key                r_out_popped, n_out_popped;
    mhpq_pkg::t_status             r_out_status, n_out_status;
    logic [mhpq_pkg::COUNT_W-1:0]  r_out_count,  n_out_count;

    mhpq_pkg::t_ram_req ram_req;
    mhpq_pkg::t_idx     left_idx;
    mhpq_pkg::t_idx     right_idx;
    mhpq_pkg::t_idx     cnt_idx;
    logic               left_ok;
    logic               right_ok;
    mhpq_pkg::t_addr    best;
    mhpq_pkg::t_key     best_key;
    logic               move_down;

    // children of the current hole and the larger one of them
    always_comb begin
        left_idx  = {r_hole, 1'b0};
        right_idx = {r_hole, 1'b1};
        cnt_idx   = {1'b0, r_cnt};
        left_ok   = (left_idx <= cnt_idx);
        right_ok  = (right_idx <= cnt_idx);
        best      = left_idx[mhpq_pkg::ADDR_W-1:0];
        best_key  = i_rdata_a;
        if (right_ok && (i_rdata_b > i_rdata_a)) begin
            best     = right_idx[mhpq_pkg::ADDR_W-1:0];
            best_key = i_rdata_b;
        end
        move_down = left_ok && (best_key > r_key);
    end

    // next state, memory requests and result staging
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_hole       = r_hole;
        n_key        = r_key;
        n_popped     = r_popped;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_popped = r_out_popped;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        ram_req      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_popped = '0;
                    n_status = mhpq_pkg::ST_OK;
                    if (i_in.op == mhpq_pkg::OP_INSERT) begin
                        if (r_cnt == mhpq_pkg::t_addr'(mhpq_pkg::MAX_ENTRIES)) begin
                            n_status = mhpq_pkg::ST_OVERFLOW;
                            n_state  = S_RES;
                        end else begin
                            // hole opens at the new last slot, fetch its parent
                            n_cnt           = r_cnt + mhpq_pkg::t_addr'(1);
                            n_hole          = r_cnt + mhpq_pkg::t_addr'(1);
                            n_key           = i_in.value;
                            ram_req.raddr_a = (r_cnt + mhpq_pkg::t_addr'(1)) >> 1;
                            n_state         = S_INS;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_status = mhpq_pkg::ST_UNDERFLOW;
                            n_state  = S_RES;
                        end else begin
                            // fetch root and last entry
                            ram_req.raddr_a = mhpq_pkg::t_addr'(1);
                            ram_req.raddr_b = r_cnt;
                            n_cnt           = r_cnt - mhpq_pkg::t_addr'(1);
                            n_state         = S_POP;
                        end
                    end
                end
            end
            S_INS: begin
                // sift up: parent word is on read port a
                ram_req.we = 1'b1;
                ram_req.waddr = r_hole;
                if ((r_hole > mhpq_pkg::t_addr'(1)) && (r_key > i_rdata_a)) begin
                    ram_req.wdata   = i_rdata_a;
                    n_hole          = r_hole >> 1;
                    ram_req.raddr_a = r_hole >> 2;
                end else begin
                    ram_req.wdata = r_key;
                    n_state       = S_RES;
                end
            end
            S_POP: begin
                // root leaves, last entry sinks from the root
                n_popped        = i_rdata_a;
                n_key           = i_rdata_b;
                n_hole          = mhpq_pkg::t_addr'(1);
                ram_req.raddr_a = mhpq_pkg::t_addr'(2);
                ram_req.raddr_b = mhpq_pkg::t_addr'(3);
                n_state         = S_DOWN;
            end
            S_DOWN: begin
                // sift down: children words on ports a and b
                ram_req.we    = 1'b1;
                ram_req.waddr = r_hole;
                if (move_down) begin
                    ram_req.wdata   = best_key;
                    n_hole          = best;
                    ram_req.raddr_a = mhpq_pkg::t_addr'({best, 1'b0});
                    ram_req.raddr_b = mhpq_pkg::t_addr'({best, 1'b1});
                end else begin
                    ram_req.wdata = r_key;
                    n_state       = S_RES;
                end
            end
            S_RES: begin
                // hand the result word to the output register once it is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_popped = r_popped;
                    n_out_status = r_status;
                    n_out_count  = mhpq_pkg::COUNT_W'(r_cnt);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, count, working registers and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_hole       <= n_hole;
        r_key        <= n_key;
        r_popped     <= n_popped;
        r_status     <= n_status;
        r_out_popped <= n_out_popped;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.popped = r_out_popped;
    assign o_out.status = r_out_status;
    assign o_out.count  = r_out_count;
    assign o_ram_req    = ram_req;

    // checks on the sequencer
    `MHPQ_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= mhpq_pkg::t_addr'(mhpq_pkg::MAX_ENTRIES), "entry count above capacity")
    `MHPQ_ASSERT(a_cnt_step, i_clk, i_rst_n, (r_cnt == $past(r_cnt)) || (r_cnt == $past(r_cnt) + mhpq_pkg::t_addr'(1)) || (r_cnt == $past(r_cnt) - mhpq_pkg::t_addr'(1)), "entry count moved by more than one")
    `MHPQ_ASSERT(a_no_slot0, i_clk, i_rst_n, ram_req.we |-> (ram_req.waddr != '0), "write to unused slot zero")
    `MHPQ_ASSERT(a_one_word, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> !i_in.ready, "second word taken while one is in work")
    `MHPQ_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> (i_in.ready && !o_out.valid), "not idle after reset")

endmodule

// ----- rtl/max_heap_priority_queue_top.sv -----
// Binary max-heap priority queue of signed 32-bit words, up to 1023 entries, held in
// a one-write two-read memory with registered reads. Each input word inserts a value
// (op 0) or pops the maximum (op 1) and yields exactly one result word with the popped
// value, a status (ok, overflow on a full heap, underflow on an empty heap) and the
// entry count after the operation. One word is in work at a time: an insert climbs
// 0 to 9 levels, a pop sinks 0 to 9 levels, and a refused word goes straight to the
// result register. Each level waits on a registered read of the heap memory; the next
// word is taken while the previous result waits at the output. The memory needs no
// clearing pass after reset.
module max_heap_priority_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mhpq_in_if.sink     i_in,
    mhpq_out_if.source  o_out
);

    mhpq_pkg::t_ram_req ram_req;
    mhpq_pkg::t_key     rdata_a;
    mhpq_pkg::t_key     rdata_b;

    // sequencer
    mhpq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_ram_req (ram_req),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b)
    );

    // heap store
    mhpq_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

endmodule

// ----- dv/heap_result_checker.sv -----
// checker that predicts and compares the heap queue result words
`timescale 1ns / 100ps

module heap_result_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    mhpq_in_if      i_op_ch,
    mhpq_out_if     i_res_ch,
    output int      o_fail_count,
    output int      o_pending
);

    // expected contents of one result word
    typedef struct {
        mhpq_pkg::t_key               popped;
        mhpq_pkg::t_status            status;
        logic [mhpq_pkg::COUNT_W-1:0] count;
    } t_heap_result;

    // predicted heap, one-based like the block's memory
    mhpq_pkg::t_key heap_keys [1:mhpq_pkg::MAX_ENTRIES];
    int             heap_size;
    int             fail_total;

    t_heap_result pending_results [$];

    // apply one operation to the predicted heap and return its result word
    function automatic t_heap_result apply_heap_op(input logic op, input mhpq_pkg::t_key value);
        t_heap_result   res;
        int             slot;
        int             left;
        int             right;
        int             best;
        mhpq_pkg::t_key tmp;
        res.popped = '0;
        res.status = mhpq_pkg::ST_OK;
        if (op == mhpq_pkg::OP_INSERT) begin
            if (heap_size >= mhpq_pkg::MAX_ENTRIES) begin
                res.status = mhpq_pkg::ST_OVERFLOW;
            end else begin
                heap_size++;
                heap_keys[heap_size] = value;
                slot = heap_size;
                // climb while the parent is strictly smaller
                while (slot > 1 && heap_keys[slot] > heap_keys[slot >> 1]) begin
                    tmp = heap_keys[slot];
                    heap_keys[slot] = heap_keys[slot >> 1];
                    heap_keys[slot >> 1] = tmp;
                    slot = slot >> 1;
                end
            end
        end else if (heap_size == 0) begin
            res.status = mhpq_pkg::ST_UNDERFLOW;
        end else begin
            res.popped = heap_keys[1];
            heap_keys[1] = heap_keys[heap_size];
            heap_size--;
            slot = 1;
            // sink toward the larger child, left wins a tie
            forever begin
                left  = 2 * slot;
                right = left + 1;
                best  = slot;
                if (left <= heap_size && heap_keys[left] > heap_keys[best])
                    best = left;
                if (right <= heap_size && heap_keys[right] > heap_keys[best])
                    best = right;
                if (best == slot)
                    break;
                tmp = heap_keys[slot];
                heap_keys[slot] = heap_keys[best];
                heap_keys[best] = tmp;
                slot = best;
            end
        end
        res.count = mhpq_pkg::COUNT_W'(heap_size);
        return res;
    endfunction

    // compare accepted result words, then predict for accepted operation words
    always @(posedge i_clk) begin
        t_heap_result want;
        if (!i_rst_n) begin
            heap_size = 0;
            fail_total = 0;
            pending_results.delete();
        end else begin
            if (i_res_ch.valid && i_res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with no operation outstanding");
                    fail_total++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_res_ch.popped !== want.popped) begin
                        $error("popped: expected %0d, got %0d", want.popped, i_res_ch.popped);
                        fail_total++;
                    end
                    if (i_res_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_res_ch.status);
                        fail_total++;
                    end
                    if (i_res_ch.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, i_res_ch.count);
                        fail_total++;
                    end
                end
            end
            if (i_op_ch.valid && i_op_ch.ready)
                pending_results.push_back(apply_heap_op(i_op_ch.op, i_op_ch.value));
        end
        o_fail_count <= fail_total;
        o_pending    <= pending_results.size();
    end

endmodule

// ----- dv/tb.sv -----
// testbench top: clock, reset, operation stimulus, result back-pressure and verdict
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int STEADY_START = 3500;
    localparam int STEADY_END   = 5500;
    localparam int HOLD_START   = 2000;
    localparam int HOLD_END     = 2400;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycle_count = 0;
    int   heap_fill = 0;
    int   fail_count;
    int   pending_count;

    mhpq_in_if  in_ch ();
    mhpq_out_if out_ch ();

    max_heap_priority_queue_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    heap_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_ch      (in_ch),
        .i_res_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side back-pressure: random stalls, one long hold-off, one steady stretch
    initial begin
        int rx_cycles;
        rx_cycles = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else begin
                rx_cycles++;
                if (rx_cycles >= HOLD_START && rx_cycles < HOLD_END)
                    out_ch.ready <= 1'b0;
                else if (rx_cycles >= STEADY_START && rx_cycles < STEADY_END)
                    out_ch.ready <= 1'b1;
                else
                    out_ch.ready <= ($urandom_range(99) >= 18);
            end
        end
    end

    // key mix: extremes, a narrow band for equal keys, full-range random
    function automatic mhpq_pkg::t_key pick_key();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return mhpq_pkg::t_key'(int'($urandom_range(8)) - 4);
            default: return mhpq_pkg::t_key'($urandom);
        endcase
    endfunction

    // offer one operation word and wait for its acceptance
    task automatic send_word(input logic op, input mhpq_pkg::t_key value);
        while (!(cycle_count >= STEADY_START && cycle_count < STEADY_END) &&
               $urandom_range(99) < 18) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op    <= op;
        in_ch.value <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        // track occupancy to steer the stimulus
        if (op == mhpq_pkg::OP_INSERT && heap_fill < mhpq_pkg::MAX_ENTRIES)
            heap_fill++;
        else if (op == mhpq_pkg::OP_POP && heap_fill > 0)
            heap_fill--;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.op    <= mhpq_pkg::OP_INSERT;
        in_ch.value <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty heap, extreme keys, equal keys, drain past empty
        send_word(mhpq_pkg::OP_POP, 32'sh7FFF_FFFF);
        send_word(mhpq_pkg::OP_INSERT, 32'sh7FFF_FFFF);
        send_word(mhpq_pkg::OP_INSERT, 32'sh8000_0000);
        send_word(mhpq_pkg::OP_INSERT, 32'sh0000_0000);
        send_word(mhpq_pkg::OP_INSERT, -32'sd1);
        send_word(mhpq_pkg::OP_INSERT, 32'sd5);
        send_word(mhpq_pkg::OP_INSERT, 32'sd5);
        send_word(mhpq_pkg::OP_INSERT, 32'sd5);
        send_word(mhpq_pkg::OP_INSERT, -32'sd1);
        repeat (9) send_word(mhpq_pkg::OP_POP, mhpq_pkg::t_key'($urandom));

        // fill to capacity with a few pops mixed in, so sinks run deep
        while (heap_fill < mhpq_pkg::MAX_ENTRIES)
            send_word(($urandom_range(99) < 10) ? mhpq_pkg::OP_POP : mhpq_pkg::OP_INSERT,
                      pick_key());

        // churn at the top: refused inserts on a full heap and refills
        repeat (40)
            send_word(($urandom_range(99) < 50) ? mhpq_pkg::OP_POP : mhpq_pkg::OP_INSERT,
                      pick_key());

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
